/* rtl/pm_pkg.sv */
// ----------------------------------------------------------------------------
// pm_pkg
// Shared constants, command codes and cell control type for the polynomial
// multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package pm_pkg;

   localparam int MAX_DEGREE  = 31;
   localparam int COEFF_WIDTH = 16;

   localparam int CELLS       = MAX_DEGREE + 1;
   localparam int CELL_IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SUM_WIDTH   = 40;

   // fixed field widths of the stream items
   localparam int CMD_WIDTH   = 2;
   localparam int IDX_WIDTH   = 5;
   localparam int IN_WIDTH    = 16;
   localparam int POWER_WIDTH = 6;

   // the command travels in tuser, the other request fields in tdata
   localparam int REQ_FIELDS_W = IDX_WIDTH + IN_WIDTH + 2 * IDX_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = POWER_WIDTH + SUM_WIDTH;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD      = REQ_DATA_W - REQ_FIELDS_W;
   localparam int RSP_PAD      = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_MULTIPLY    = 2'd2
   } cmd_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                   step;
      logic                   restart;
      logic [COEFF_WIDTH-1:0] x_value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/polynomial_multiply.sv */
// ----------------------------------------------------------------------------
// polynomial_multiply
// Polynomial product by a chain of multiply-accumulate cells in transposed
// convolution form; the second operand is streamed through the chain.
// ----------------------------------------------------------------------------
// load items: one per cycle while no multiply runs, no result
// multiply: df+ds+1 chain steps, one result coefficient per step; the
//   transfer starts the run, the first step registers the first result, and the
//   next item is taken only after the last step
// a stalled result stalls the whole chain
// reset clears sequencing and output valid; coefficients are kept as written
`default_nettype none

module polynomial_multiply (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // power_index, coeff_value, degree_first, degree_second, zero pad
   input  wire logic [pm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  wire logic [pm_pkg::CMD_WIDTH-1:0]     req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // result_power, result_value, zero pad
   output logic [pm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int CW = pm_pkg::COEFF_WIDTH;

   logic [pm_pkg::CMD_WIDTH-1:0] req_cmd;
   logic [pm_pkg::IDX_WIDTH-1:0] req_power_index;
   logic [pm_pkg::IN_WIDTH-1:0]  req_coeff_value;
   logic [pm_pkg::IDX_WIDTH-1:0] req_degree_first;
   logic [pm_pkg::IDX_WIDTH-1:0] req_degree_second;

   assign req_cmd           = req_tuser;
   assign req_power_index   = req_tdata[4:0];
   assign req_coeff_value   = req_tdata[20:5];
   assign req_degree_first  = req_tdata[25:21];
   assign req_degree_second = req_tdata[30:26];

   logic                              run_ff, run_in;
   logic [pm_pkg::POWER_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [pm_pkg::POWER_WIDTH-1:0]    top_ff, top_in;
   logic [pm_pkg::CELL_IDX_W-1:0]     df_ff, df_in;
   logic [pm_pkg::CELL_IDX_W-1:0]     ds_ff, ds_in;
   logic                              out_valid_ff, out_valid_in;
   logic [pm_pkg::POWER_WIDTH-1:0]    power_ff, power_in;
   logic                              last_ff, last_in;
   logic [CW-1:0]                     second_ff [pm_pkg::CELLS];

   logic                              in_xfer;
   logic                              idx_ok;
   logic                              step;
   logic [CW-1:0]                     load_value;
   logic [pm_pkg::CELL_IDX_W-1:0]     load_idx;
   pm_pkg::cell_ctrl_type             ctrl;
   logic signed [pm_pkg::SUM_WIDTH-1:0] sum_chain [pm_pkg::CELLS+1];

   assign req_tready = !run_ff;
   assign in_xfer    = req_tvalid && req_tready;
   assign step       = run_ff && (!out_valid_ff || rsp_tready);
   assign idx_ok     = req_power_index <= pm_pkg::IDX_WIDTH'(pm_pkg::MAX_DEGREE);
   assign load_idx   = pm_pkg::CELL_IDX_W'(req_power_index);
   assign load_value = CW'($signed(req_coeff_value));

   always_comb begin
      // degrees above MAX_DEGREE saturate
      df_in = (req_degree_first > pm_pkg::IDX_WIDTH'(pm_pkg::MAX_DEGREE))
            ? pm_pkg::CELL_IDX_W'(pm_pkg::MAX_DEGREE)
            : pm_pkg::CELL_IDX_W'(req_degree_first);
      ds_in = (req_degree_second > pm_pkg::IDX_WIDTH'(pm_pkg::MAX_DEGREE))
            ? pm_pkg::CELL_IDX_W'(pm_pkg::MAX_DEGREE)
            : pm_pkg::CELL_IDX_W'(req_degree_second);
      top_in = pm_pkg::POWER_WIDTH'(df_in) + pm_pkg::POWER_WIDTH'(ds_in);
   end

   always_comb begin
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      power_in     = power_ff;
      last_in      = last_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (step) begin
         cnt_in       = cnt_ff + pm_pkg::POWER_WIDTH'(1);
         out_valid_in = 1'b1;
         power_in     = cnt_ff;
         last_in      = (cnt_ff == top_ff);
         if (cnt_ff == top_ff) begin
            run_in = 1'b0;
         end
      end
      if (in_xfer && (req_cmd == pm_pkg::CMD_MULTIPLY)) begin
         run_in = 1'b1;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
      last_ff  <= last_in;
      if (in_xfer && (req_cmd == pm_pkg::CMD_MULTIPLY)) begin
         top_ff <= top_in;
         df_ff  <= df_in;
         ds_ff  <= ds_in;
      end
      if (in_xfer && (req_cmd == pm_pkg::CMD_LOAD_SECOND) && idx_ok) begin
         second_ff[load_idx] <= load_value;
      end
   end

   // second operand enters the chain lowest power first, then zeros
   always_comb begin
      ctrl.step    = step;
      ctrl.restart = (cnt_ff == '0);
      ctrl.x_value = (cnt_ff <= pm_pkg::POWER_WIDTH'(ds_ff))
                   ? second_ff[cnt_ff[pm_pkg::CELL_IDX_W-1:0]]
                   : '0;
   end

   assign sum_chain[pm_pkg::CELLS] = '0;

   for (genvar i = 0; i < pm_pkg::CELLS; i++) begin : g_cell
      logic cell_load;
      logic cell_active;

      assign cell_load   = in_xfer && (req_cmd == pm_pkg::CMD_LOAD_FIRST) && idx_ok
                           && (load_idx == pm_pkg::CELL_IDX_W'(i));
      assign cell_active = (pm_pkg::CELL_IDX_W'(i) <= df_ff);

      pm_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_en    (cell_load),
         .load_value (load_value),
         .active     (cell_active),
         .sum_in     (sum_chain[i+1]),
         .sum_out    (sum_chain[i])
      );
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{pm_pkg::RSP_PAD{1'b0}}, sum_chain[0], power_ff};

   // the chain never steps past the highest power
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff <= top_ff))
      else $error("step count beyond highest power");

   // finishing a product leaves its last coefficient on the output
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(run_ff) && !$past(reset)) |-> (rsp_tvalid && rsp_tlast))
      else $error("product ended without a last result");

   // a result that is not the last one means more are still to come
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |-> run_ff)
      else $error("non-last result with no product in progress");

endmodule

`default_nettype wire

/* rtl/pm_cell.sv */
// ----------------------------------------------------------------------------
// pm_cell
// One tap of the transposed convolution chain: holds one first-operand
// coefficient and a partial sum that moves one cell toward the output per step.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_cell (
   input  wire logic                                clock,
   input  wire pm_pkg::cell_ctrl_type               ctrl,
   input  wire logic                                load_en,
   input  wire logic [pm_pkg::COEFF_WIDTH-1:0]      load_value,
   input  wire logic                                active,
   input  wire logic signed [pm_pkg::SUM_WIDTH-1:0] sum_in,
   output logic signed [pm_pkg::SUM_WIDTH-1:0]      sum_out
);

   logic signed [pm_pkg::COEFF_WIDTH-1:0]   coeff_ff;
   logic signed [2*pm_pkg::COEFF_WIDTH-1:0] product;
   logic signed [pm_pkg::SUM_WIDTH-1:0]     carry;
   logic signed [pm_pkg::SUM_WIDTH-1:0]     sum_ff;
   logic signed [pm_pkg::SUM_WIDTH-1:0]     sum_in_next;

   always_comb begin
      // cells above the first operand's degree contribute nothing
      if (active) begin
         product = coeff_ff * $signed(ctrl.x_value);
      end else begin
         product = '0;
      end
      // first step of a product drops what the neighbor still holds
      carry       = ctrl.restart ? '0 : sum_in;
      sum_in_next = pm_pkg::SUM_WIDTH'(product) + carry;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         coeff_ff <= load_value;
      end
      if (ctrl.step) begin
         sum_ff <= sum_in_next;
      end
   end

   assign sum_out = sum_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_polynomial_multiply.sv */
// ----------------------------------------------------------------------------
// tb_polynomial_multiply
// Self-checking testbench for the polynomial multiplier. A queue of request
// transfers (coefficient loads, multiplies and unused commands) feeds a
// clocked driver. Accepted requests update a local copy of both operands and
// compute the expected product coefficients, which a clocked monitor checks
// field by field against every result transfer. Sender and receiver idle at
// varying rates, and one long receiver hold backs the block up.
// ----------------------------------------------------------------------------

module tb_polynomial_multiply;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 40;
   localparam int MAX_PRINTED  = 40;

   localparam logic [pm_pkg::CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   // request field positions inside req_tdata
   localparam int POS_IDX   = 0;
   localparam int POS_COEFF = POS_IDX + pm_pkg::IDX_WIDTH;
   localparam int POS_DEG_A = POS_COEFF + pm_pkg::IN_WIDTH;
   localparam int POS_DEG_B = POS_DEG_A + pm_pkg::IDX_WIDTH;

   typedef struct {
      logic [pm_pkg::CMD_WIDTH-1:0]       cmd;
      logic [pm_pkg::IDX_WIDTH-1:0]       power;
      logic signed [pm_pkg::IN_WIDTH-1:0] coeff;
      logic [pm_pkg::IDX_WIDTH-1:0]       deg_a;
      logic [pm_pkg::IDX_WIDTH-1:0]       deg_b;
   } req_item_type;

   typedef struct {
      logic [pm_pkg::POWER_WIDTH-1:0]      power;
      logic signed [pm_pkg::SUM_WIDTH-1:0] value;
      logic                                last;
   } product_coeff_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [pm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [pm_pkg::CMD_WIDTH-1:0]  req_tuser  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [pm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                          rsp_tlast;

   req_item_type      pending_requests[$];
   product_coeff_type expected_coeffs[$];

   // operand copies seen by the predictor, in acceptance order
   logic signed [pm_pkg::IN_WIDTH-1:0] first_coeff  [0:pm_pkg::MAX_DEGREE];
   logic signed [pm_pkg::IN_WIDTH-1:0] second_coeff [0:pm_pkg::MAX_DEGREE];
   // written flags tracked while the queue is filled
   bit first_written  [0:pm_pkg::MAX_DEGREE];
   bit second_written [0:pm_pkg::MAX_DEGREE];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int items_queued   = 0;
   int loads_sent     = 0;
   int multiplies_sent = 0;
   int coeffs_checked = 0;

   polynomial_multiply i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLOCK_HALF clock = ~clock;

   task automatic note_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   function automatic logic [pm_pkg::REQ_DATA_W-1:0] pack_request(input req_item_type it);
      logic [pm_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[POS_IDX +: pm_pkg::IDX_WIDTH]   = it.power;
      d[POS_COEFF +: pm_pkg::IN_WIDTH]  = it.coeff;
      d[POS_DEG_A +: pm_pkg::IDX_WIDTH] = it.deg_a;
      d[POS_DEG_B +: pm_pkg::IDX_WIDTH] = it.deg_b;
      return d;
   endfunction

   function automatic logic signed [pm_pkg::IN_WIDTH-1:0] rand_coeff();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return '0;
         3: return -16'sd1;
         default: return pm_pkg::IN_WIDTH'($urandom);
      endcase
   endfunction

   // mostly short operands, now and then a long one
   function automatic int rand_degree();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 4);
      if (r < 95) return $urandom_range(5, 12);
      return $urandom_range(13, pm_pkg::MAX_DEGREE);
   endfunction

   function automatic req_item_type make_load(input logic [pm_pkg::CMD_WIDTH-1:0] c,
                                              input int idx,
                                              input logic signed [pm_pkg::IN_WIDTH-1:0] v);
      req_item_type it;
      it.cmd   = c;
      it.power = pm_pkg::IDX_WIDTH'(idx);
      it.coeff = v;
      it.deg_a = pm_pkg::IDX_WIDTH'($urandom);
      it.deg_b = pm_pkg::IDX_WIDTH'($urandom);
      return it;
   endfunction

   function automatic req_item_type make_multiply(input int da, input int db);
      req_item_type it;
      it.cmd   = pm_pkg::CMD_MULTIPLY;
      it.power = pm_pkg::IDX_WIDTH'($urandom);
      it.coeff = pm_pkg::IN_WIDTH'($urandom);
      it.deg_a = pm_pkg::IDX_WIDTH'(da);
      it.deg_b = pm_pkg::IDX_WIDTH'(db);
      return it;
   endfunction

   function automatic req_item_type make_unused();
      req_item_type it;
      it = make_multiply($urandom_range(0, pm_pkg::MAX_DEGREE),
                         $urandom_range(0, pm_pkg::MAX_DEGREE));
      it.cmd = CMD_UNUSED;
      return it;
   endfunction

   task automatic push_item(input req_item_type it);
      case (it.cmd)
         pm_pkg::CMD_LOAD_FIRST:  first_written[it.power] = 1'b1;
         pm_pkg::CMD_LOAD_SECOND: second_written[it.power] = 1'b1;
         default: ;
      endcase
      if (it.cmd != CMD_UNUSED) items_queued++;
      pending_requests.push_back(it);
   endtask

   // loads every entry a multiply of this size reads that is still unwritten,
   // rewrites some others, shuffles the loads, then may queue an unused command and a multiply
   task automatic queue_sequence(input int deg_a, input int deg_b, input bit do_multiply,
                                 input bit fixed,
                                 input logic signed [pm_pkg::IN_WIDTH-1:0] fixed_val);
      req_item_type loads[$];
      req_item_type tmp;
      int k;
      int j;
      for (k = 0; k <= deg_a; k++) begin
         if (!first_written[k] || fixed || $urandom_range(0, 1) == 1) begin
            loads.push_back(make_load(pm_pkg::CMD_LOAD_FIRST, k,
                                      fixed ? fixed_val : rand_coeff()));
         end
      end
      for (k = 0; k <= deg_b; k++) begin
         if (!second_written[k] || fixed || $urandom_range(0, 1) == 1) begin
            loads.push_back(make_load(pm_pkg::CMD_LOAD_SECOND, k,
                                      fixed ? fixed_val : rand_coeff()));
         end
      end
      if (!fixed && $urandom_range(0, 3) == 0) begin
         loads.push_back(make_load($urandom_range(0, 1) ? pm_pkg::CMD_LOAD_SECOND
                                                        : pm_pkg::CMD_LOAD_FIRST,
                                   $urandom_range(0, pm_pkg::MAX_DEGREE), rand_coeff()));
      end
      for (k = loads.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = loads[k];
         loads[k] = loads[j];
         loads[j] = tmp;
      end
      foreach (loads[n]) push_item(loads[n]);
      if (!fixed && $urandom_range(0, 19) == 0) push_item(make_unused());
      if (do_multiply) push_item(make_multiply(deg_a, deg_b));
   endtask

   task automatic wait_all_done();
      while (pending_requests.size() != 0 || expected_coeffs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic predict_product(input req_item_type it);
      logic signed [pm_pkg::SUM_WIDTH-1:0] sums [0:2*pm_pkg::MAX_DEGREE];
      logic signed [pm_pkg::SUM_WIDTH-1:0] a;
      logic signed [pm_pkg::SUM_WIDTH-1:0] b;
      product_coeff_type c;
      int i;
      int j;
      int top;
      case (it.cmd)
         pm_pkg::CMD_LOAD_FIRST: begin
            first_coeff[it.power] = it.coeff;
            loads_sent++;
         end
         pm_pkg::CMD_LOAD_SECOND: begin
            second_coeff[it.power] = it.coeff;
            loads_sent++;
         end
         pm_pkg::CMD_MULTIPLY: begin
            multiplies_sent++;
            top = int'(it.deg_a) + int'(it.deg_b);
            for (i = 0; i <= top; i++) sums[i] = '0;
            for (i = 0; i <= int'(it.deg_a); i++) begin
               for (j = 0; j <= int'(it.deg_b); j++) begin
                  a = first_coeff[i];
                  b = second_coeff[j];
                  sums[i+j] = sums[i+j] + a * b;
               end
            end
            for (i = 0; i <= top; i++) begin
               c.power = pm_pkg::POWER_WIDTH'(i);
               c.value = sums[i];
               c.last  = (i == top);
               expected_coeffs.push_back(c);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_product(pending_requests.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pack_request(pending_requests[0]);
               req_tuser  <= pending_requests[0].cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      product_coeff_type want;
      logic [pm_pkg::POWER_WIDTH-1:0]      got_power;
      logic signed [pm_pkg::SUM_WIDTH-1:0] got_value;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_power = rsp_tdata[0 +: pm_pkg::POWER_WIDTH];
         got_value = rsp_tdata[pm_pkg::POWER_WIDTH +: pm_pkg::SUM_WIDTH];
         if (expected_coeffs.size() == 0) begin
            note_mismatch($sformatf("result transfer with nothing expected, power %0d value %0d",
                                    got_power, got_value));
         end else begin
            want = expected_coeffs.pop_front();
            coeffs_checked++;
            if (got_power != want.power || got_value != want.value || rsp_tlast != want.last) begin
               note_mismatch($sformatf("power %0d/%0d value %0d/%0d last %0b/%0b (got/want)",
                                       got_power, want.power, got_value, want.value,
                                       rsp_tlast, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int idle_send [4];
      int idle_recv [4];
      idle_send = '{0, 68, 0, 6};
      idle_recv = '{0, 0, 68, 6};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, degree-zero and uneven products
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, 0, 16'sd32767));
      push_item(make_load(pm_pkg::CMD_LOAD_SECOND, 0, -16'sd32768));
      push_item(make_multiply(0, 0));
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, 1, -16'sd32768));
      push_item(make_load(pm_pkg::CMD_LOAD_SECOND, 1, -16'sd32768));
      push_item(make_multiply(1, 1));
      push_item(make_unused());
      push_item(make_multiply(1, 0));
      push_item(make_multiply(0, 1));
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, pm_pkg::MAX_DEGREE, -16'sd1));
      push_item(make_load(pm_pkg::CMD_LOAD_SECOND, pm_pkg::MAX_DEGREE, 16'sd1));
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, 0, 16'sd0));
      push_item(make_load(pm_pkg::CMD_LOAD_SECOND, 1, -16'sd1));
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, 2, 16'sd256));
      push_item(make_multiply(2, 1));
      push_item(make_load(pm_pkg::CMD_LOAD_FIRST, 0, -16'sd1));
      push_item(make_load(pm_pkg::CMD_LOAD_SECOND, 0, -16'sd1));
      push_item(make_multiply(0, 0));
      // sender holds back until the block has emptied
      wait_all_done();

      items_queued = 0;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_send[phase];
         recv_stall_pct = idle_recv[phase];
         if (phase == 0) begin
            // long receiver hold while full-size operands stream in;
            // all coefficients at the negative extreme give the largest sums
            hold_asked = hold_asked + 1;
            queue_sequence(pm_pkg::MAX_DEGREE, pm_pkg::MAX_DEGREE, 1'b1, 1'b1, -16'sd32768);
            // more traffic waits behind the held product
            queue_sequence(rand_degree(), rand_degree(), 1'b1, 1'b0, '0);
         end
         if (phase == 2) queue_sequence(pm_pkg::MAX_DEGREE, 17, 1'b1, 1'b0, '0);
         while (items_queued < PHASE_ITEMS * (phase + 1)) begin
            queue_sequence(rand_degree(), rand_degree(), $urandom_range(0, 9) != 0, 1'b0, '0);
         end
         wait_all_done();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_coeffs.size() != 0) begin
         note_mismatch($sformatf("%0d expected coefficients never arrived",
                                 expected_coeffs.size()));
      end
      $display("run covered %0d coefficient loads and %0d multiplies, %0d product terms checked",
               loads_sent, multiplies_sent, coeffs_checked);
      $display("traffic: no idling, sender idling, receiver stalling, both, one long hold");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
